@@ hdl/vdppl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdppl_pkg
// Shared types and constants for the VDP port and line interrupt unit:
// port operation codes, register numbers, memory sizes and the beat layout.
// ----------------------------------------------------------------------------
package vdppl_pkg;

  // operation carried in the input tuser field
  typedef enum logic [3:0] {
    OP_CTRL_WR   = 4'd0,
    OP_DATA_WR   = 4'd1,
    OP_DATA_RD   = 4'd2,
    OP_LINE_TICK = 4'd3,
    OP_CLR_FRAME = 4'd4,
    OP_CLR_LINE  = 4'd5,
    OP_CLR_IRQ   = 4'd6,
    OP_POLL_PAL  = 4'd7,
    OP_REG_RD    = 4'd8,
    OP_COLOUR_RD = 4'd9
  } op_t;

  // source of the data port read byte, resolved in the cycle after accept
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_VRAM = 2'd1,
    RD_CRAM = 2'd2,
    RD_ONES = 2'd3
  } rd_src_t;

  // configuration register indexes
  localparam logic [1:0] CFG_HANDHELD = 2'd0;
  localparam logic [1:0] CFG_RENDER   = 2'd1;

  // mode register numbers and bits
  localparam logic [3:0] REG_MODE0     = 4'd0;
  localparam logic [3:0] REG_MODE1     = 4'd1;
  localparam logic [3:0] REG_LINE_CNT  = 4'd10;
  localparam int         MODE0_LINE_IE = 4;
  localparam int         MODE1_FRAME_IE = 5;
  localparam logic [3:0] REG_WR_CODE   = 4'h8;
  localparam int         NUM_REGS      = 16;

  // memory sizes
  localparam int VRAM_DEPTH = 16384;
  localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
  localparam int CRAM_BANK_DEPTH = 32;
  localparam int CRAM_AW    = $clog2(CRAM_BANK_DEPTH);

  // line counter landmarks
  localparam logic [8:0] LINE_ACTIVE_END = 9'd192;
  localparam logic [8:0] LINE_FRAME_IRQ  = 9'd193;
  localparam int         LAST_LINE_DEF   = 261;

  // beat widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;

endpackage

@@ hdl/vdppl_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdppl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vdppl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/vdp_port_and_line_interrupt_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdp_port_and_line_interrupt_unit
// CPU-facing side of a TMS9918-style VDP: control and data ports, mode
// registers, line counter with frame and line interrupts, palette decode.
// ----------------------------------------------------------------------------
// The unit takes one operation beat per cycle while s_tready is high and
// returns exactly one result beat for each, through a middle stage and the
// output register. All register state is updated at the accepting edge; the
// middle stage waits for the registered read of video RAM (16K x 8) and
// the two 32 x 8 colour RAM banks (even and odd entries), whose data is merged
// and colour-decoded on the way into the output register. A full output
// register with a waiting stage behind it stalls s_tready; otherwise input
// beats flow every cycle. The memories are not cleared after reset.
module vdp_port_and_line_interrupt_unit #(
  parameter int LAST_LINE = vdppl_pkg::LAST_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], entry_index[12:8], zero pad
  input  logic [3:0]  s_tuser,   // op[3:0]
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_byte[7:0], int_request[8], frame_finished[9], frame_irq_flag[10],
  // line_irq_flag[11], irq_pending[12], line_number[21:13],
  // palette_changed[22], register_value[30:23], red[38:31], green[46:39],
  // blue[54:47], zero pad[55]
  output logic [55:0] m_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_data
);

  import vdppl_pkg::*;

  // configuration
  logic handheld_mode;
  logic render_enable;

  // port and interrupt state
  logic [7:0]  mode_regs [NUM_REGS];
  logic [15:0] access_addr;
  logic        second_pending;
  logic [7:0]  first_latch;
  logic [7:0]  line_down;
  logic [8:0]  vcount;
  logic        frame_flag;
  logic        line_flag;
  logic        pending_flag;
  logic        pal_dirty;

  logic [15:0] access_addr_next;
  logic        second_pending_next;
  logic [7:0]  first_latch_next;
  logic [7:0]  line_down_next;
  logic [8:0]  vcount_next;
  logic        frame_flag_next;
  logic        line_flag_next;
  logic        pending_flag_next;
  logic        pal_dirty_next;
  logic        reg_wr;
  logic [3:0]  reg_wr_idx;

  // per-item results known at accept
  logic        irq_res;
  logic        fin_res;
  logic        pal_res;
  logic [7:0]  regv_res;
  rd_src_t     rd_src;

  // memory ports
  logic               vram_wr;
  logic [7:0]         vram_q;
  logic               cram_wr_even;
  logic               cram_wr_odd;
  logic [CRAM_AW-1:0] cram_wr_row;
  logic [CRAM_AW-1:0] cram_rd_row;
  logic [7:0]         cram_q_even;
  logic [7:0]         cram_q_odd;

  // middle stage
  logic       s1_valid;
  rd_src_t    s1_rd_src;
  logic       s1_bank;
  logic       s1_colour;
  logic       s1_hh;
  logic       s1_irq;
  logic       s1_fin;
  logic       s1_ff;
  logic       s1_lf;
  logic       s1_pf;
  logic [8:0] s1_vcount;
  logic       s1_pal;
  logic [7:0] s1_regv;

  logic       accept;
  logic       advance;
  op_t        in_op;
  logic [7:0] in_byte;
  logic [4:0] in_entry;
  logic [7:0] reload;
  logic       line_ie;
  logic       frame_ie;
  logic [9:0] vcount_inc;

  logic [7:0] rd_byte;
  logic [7:0] sel_c;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign in_op    = op_t'(s_tuser);
  assign in_byte  = s_tdata[7:0];
  assign in_entry = s_tdata[12:8];
  assign reload   = mode_regs[REG_LINE_CNT];
  assign line_ie  = mode_regs[REG_MODE0][MODE0_LINE_IE];
  assign frame_ie = mode_regs[REG_MODE1][MODE1_FRAME_IE];

  // handshake
  assign advance   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      handheld_mode <= 1'b0;
      render_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_HANDHELD) begin
        handheld_mode <= cfg_data;
      end else if (cfg_index == CFG_RENDER) begin
        render_enable <= cfg_data;
      end
    end
  end

  // next state and per-item results
  always_comb begin
    logic [7:0] ld_t;
    access_addr_next    = access_addr;
    second_pending_next = second_pending;
    first_latch_next    = first_latch;
    line_down_next      = line_down;
    vcount_next         = vcount;
    frame_flag_next     = frame_flag;
    line_flag_next      = line_flag;
    pending_flag_next   = pending_flag;
    pal_dirty_next      = pal_dirty;
    reg_wr              = 1'b0;
    reg_wr_idx          = in_byte[3:0];
    irq_res             = 1'b0;
    fin_res             = 1'b0;
    pal_res             = 1'b0;
    regv_res            = 8'd0;
    rd_src              = RD_NONE;
    vram_wr             = 1'b0;
    cram_wr_even        = 1'b0;
    cram_wr_odd         = 1'b0;
    ld_t                = line_down;
    vcount_inc          = {1'b0, vcount} + 10'd1;
    case (in_op)
      OP_CTRL_WR: begin
        if (!second_pending) begin
          second_pending_next = 1'b1;
          first_latch_next    = in_byte;
        end else begin
          second_pending_next = 1'b0;
          if (in_byte[7:4] == REG_WR_CODE) begin
            reg_wr           = 1'b1;
            access_addr_next = 16'd0;
          end else begin
            access_addr_next = {in_byte, first_latch};
          end
        end
      end
      OP_DATA_WR: begin
        second_pending_next = 1'b0;
        if (access_addr[15:14] != 2'b11) begin
          vram_wr = 1'b1;
        end else begin
          cram_wr_even   = !access_addr[0];
          cram_wr_odd    = access_addr[0];
          pal_dirty_next = 1'b1;
        end
        access_addr_next = access_addr + 16'd1;
      end
      OP_DATA_RD: begin
        second_pending_next = 1'b0;
        if (!access_addr[15]) begin
          rd_src = RD_VRAM;
        end else if (access_addr[15:14] == 2'b11) begin
          rd_src = RD_CRAM;
        end else begin
          rd_src = RD_ONES;
        end
        access_addr_next = access_addr + 16'd1;
      end
      OP_LINE_TICK: begin
        if (vcount <= LINE_ACTIVE_END) begin
          if (vcount == LINE_ACTIVE_END) begin
            frame_flag_next = 1'b1;
          end
          if (vcount == 9'd0) begin
            ld_t = reload;
          end
          if (ld_t == 8'd0) begin
            line_down_next = reload;
            line_flag_next = 1'b1;
          end else begin
            line_down_next = ld_t - 8'd1;
          end
          if (line_ie && line_flag_next) begin
            pending_flag_next = 1'b1;
            irq_res           = 1'b1;
          end
        end else begin
          if (vcount == LINE_FRAME_IRQ && frame_ie && frame_flag) begin
            irq_res           = 1'b1;
            pending_flag_next = 1'b1;
          end
          line_down_next = reload;
        end
        if (vcount_inc > 10'(LAST_LINE)) begin
          vcount_next = 9'd0;
          fin_res     = render_enable;
        end else begin
          vcount_next = vcount_inc[8:0];
        end
      end
      OP_CLR_FRAME: frame_flag_next = 1'b0;
      OP_CLR_LINE:  line_flag_next = 1'b0;
      OP_CLR_IRQ:   pending_flag_next = 1'b0;
      OP_POLL_PAL: begin
        pal_res        = pal_dirty;
        pal_dirty_next = 1'b0;
      end
      OP_REG_RD:    regv_res = mode_regs[in_entry[3:0]];
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mode_regs[i] <= 8'd0;
      end
      access_addr    <= 16'd0;
      second_pending <= 1'b0;
      first_latch    <= 8'd0;
      line_down      <= 8'd0;
      vcount         <= 9'd0;
      frame_flag     <= 1'b0;
      line_flag      <= 1'b0;
      pending_flag   <= 1'b0;
      pal_dirty      <= 1'b0;
    end else if (accept) begin
      if (reg_wr) begin
        mode_regs[reg_wr_idx] <= first_latch;
      end
      access_addr    <= access_addr_next;
      second_pending <= second_pending_next;
      first_latch    <= first_latch_next;
      line_down      <= line_down_next;
      vcount         <= vcount_next;
      frame_flag     <= frame_flag_next;
      line_flag      <= line_flag_next;
      pending_flag   <= pending_flag_next;
      pal_dirty      <= pal_dirty_next;
    end
  end

  // colour RAM rows: even and odd entries live in separate banks
  assign cram_wr_row = handheld_mode ? access_addr[5:1] : {1'b0, access_addr[4:1]};
  always_comb begin
    if (in_op == OP_COLOUR_RD) begin
      cram_rd_row = handheld_mode ? in_entry : {1'b0, in_entry[4:1]};
    end else begin
      cram_rd_row = access_addr[5:1];
    end
  end

  vdppl_ram #(
    .WIDTH (8),
    .DEPTH (VRAM_DEPTH)
  ) u_vram (
    .clk     (clk),
    .wr_en   (accept && vram_wr),
    .wr_addr (access_addr[VRAM_AW-1:0]),
    .wr_data (in_byte),
    .rd_en   (accept),
    .rd_addr (access_addr[VRAM_AW-1:0]),
    .rd_data (vram_q)
  );

  vdppl_ram #(
    .WIDTH (8),
    .DEPTH (CRAM_BANK_DEPTH)
  ) u_cram_even (
    .clk     (clk),
    .wr_en   (accept && cram_wr_even),
    .wr_addr (cram_wr_row),
    .wr_data (in_byte),
    .rd_en   (accept),
    .rd_addr (cram_rd_row),
    .rd_data (cram_q_even)
  );

  vdppl_ram #(
    .WIDTH (8),
    .DEPTH (CRAM_BANK_DEPTH)
  ) u_cram_odd (
    .clk     (clk),
    .wr_en   (accept && cram_wr_odd),
    .wr_addr (cram_wr_row),
    .wr_data (in_byte),
    .rd_en   (accept),
    .rd_addr (cram_rd_row),
    .rd_data (cram_q_odd)
  );

  // middle stage: waits for the memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd_src <= rd_src;
      s1_bank   <= (in_op == OP_COLOUR_RD) ? in_entry[0] : access_addr[0];
      s1_colour <= (in_op == OP_COLOUR_RD);
      s1_hh     <= handheld_mode;
      s1_irq    <= irq_res;
      s1_fin    <= fin_res;
      s1_ff     <= frame_flag_next;
      s1_lf     <= line_flag_next;
      s1_pf     <= pending_flag_next;
      s1_vcount <= vcount_next;
      s1_pal    <= pal_res;
      s1_regv   <= regv_res;
    end
  end

  // read byte select
  assign sel_c = s1_bank ? cram_q_odd : cram_q_even;
  always_comb begin
    case (s1_rd_src)
      RD_VRAM: rd_byte = vram_q;
      RD_CRAM: rd_byte = sel_c;
      RD_ONES: rd_byte = 8'hff;
      default: rd_byte = 8'd0;
    endcase
  end

  // colour decode, top bits only
  always_comb begin
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    if (s1_colour) begin
      if (s1_hh) begin
        red   = {cram_q_even[3:1], 5'd0};
        green = {cram_q_even[7:5], 5'd0};
        blue  = {cram_q_odd[3:1], 5'd0};
      end else begin
        red   = {sel_c[1:0], 6'd0};
        green = {sel_c[3:2], 6'd0};
        blue  = {sel_c[5:4], 6'd0};
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, blue, green, red, s1_regv, s1_pal, s1_vcount,
                  s1_pf, s1_lf, s1_ff, s1_fin, s1_irq, rd_byte};
    end
  end

endmodule

@@ tb/tb_vdp_port_and_line_interrupt_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vdp_port_and_line_interrupt_unit
// Streams port operations and line ticks into the VDP port and line interrupt
// unit and checks every result beat against a cycle-free model of the ports,
// the line counter and the interrupt flags. A short directed pass hits the
// address wrap, the unmapped read region, register writes and flag clears;
// then three randomized sections under different palette and render settings
// and different stall patterns run address sequences, register writes, tick
// bursts across whole frames and miscellaneous operations.
// ----------------------------------------------------------------------------
module tb_vdp_port_and_line_interrupt_unit;
  import vdppl_pkg::*;

  localparam int FRAME_LAST_LINE = 261;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 8;
  // op codes the block leaves without effect
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  // one result beat, laid out as on m_tdata[54:0]
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] reg_value;
    logic       pal_changed;
    logic [8:0] line_num;
    logic       irq_pend;
    logic       line_irq;
    logic       frame_irq;
    logic       frame_done;
    logic       int_req;
    logic [7:0] rd_byte;
  } vdp_result_t;

  // model of the unit plus the queue of results it still owes
  class vdp_result_board;
    logic [7:0] vram [VRAM_DEPTH];
    bit         vram_written [VRAM_DEPTH];
    logic [7:0] cram [64];
    bit         cram_written [64];
    logic [7:0] mode_regs [NUM_REGS];
    logic [15:0] addr;
    bit          second_byte;
    logic [7:0]  first_byte;
    logic [7:0]  line_down;
    logic [8:0]  vcount;
    bit          frame_f, line_f, pend_f, pal_dirty;
    bit          handheld, render;
    vdp_result_t owed_results [$];
    int          errors;

    function new();
      foreach (vram_written[i]) vram_written[i] = 1'b0;
      foreach (cram_written[i]) cram_written[i] = 1'b0;
      foreach (mode_regs[i]) mode_regs[i] = 8'h00;
      addr = '0;
      second_byte = 1'b0;
      first_byte = '0;
      line_down = '0;
      vcount = '0;
      frame_f = 1'b0;
      line_f = 1'b0;
      pend_f = 1'b0;
      pal_dirty = 1'b0;
      handheld = 1'b0;
      render = 1'b1;
      errors = 0;
    endfunction

    function void set_config(logic [1:0] idx, bit v);
      if (idx == CFG_HANDHELD) handheld = v;
      else if (idx == CFG_RENDER) render = v;
    endfunction

    // false when the op would read memory that was never written
    function bit read_ok(logic [3:0] op, logic [4:0] n);
      if (op == OP_DATA_RD) begin
        if (!addr[15]) return vram_written[addr[13:0]];
        if (addr[15:14] == 2'b11) return cram_written[addr[5:0]];
      end else if (op == OP_COLOUR_RD) begin
        if (handheld) return cram_written[{n, 1'b0}] && cram_written[{n, 1'b1}];
        return cram_written[{1'b0, n}];
      end
      return 1'b1;
    endfunction

    // line counter, down counter and interrupt flags for one tick
    function void line_tick(output logic irq, output logic fin);
      logic [7:0] reload;
      reload = mode_regs[REG_LINE_CNT];
      irq = 1'b0;
      fin = 1'b0;
      if (vcount <= LINE_ACTIVE_END) begin
        if (vcount == LINE_ACTIVE_END) frame_f = 1'b1;
        if (vcount == 0) line_down = reload;
        if (line_down == 0) begin
          line_down = reload;
          line_f = 1'b1;
          if (mode_regs[REG_MODE0][MODE0_LINE_IE]) pend_f = 1'b1;
        end else begin
          line_down = line_down - 8'd1;
        end
        if (mode_regs[REG_MODE0][MODE0_LINE_IE] && line_f) begin
          pend_f = 1'b1;
          irq = 1'b1;
        end
      end else begin
        if (vcount == LINE_FRAME_IRQ && mode_regs[REG_MODE1][MODE1_FRAME_IE] && frame_f) begin
          irq = 1'b1;
          pend_f = 1'b1;
        end
        line_down = reload;
      end
      if (vcount >= FRAME_LAST_LINE) begin
        vcount = '0;
        fin = render;
      end else begin
        vcount = vcount + 9'd1;
      end
    endfunction

    // apply one accepted beat and queue the result it must produce
    function void note_accepted(logic [3:0] op, logic [7:0] d, logic [4:0] n);
      vdp_result_t r;
      logic [5:0]  ci;
      logic [7:0]  lo, hi, c;
      logic        irq, fin;
      r = '0;
      case (op)
        OP_CTRL_WR: begin
          if (!second_byte) begin
            second_byte = 1'b1;
            first_byte = d;
          end else begin
            second_byte = 1'b0;
            if (d[7:4] == REG_WR_CODE) begin
              mode_regs[d[3:0]] = first_byte;
              addr = '0;
            end else begin
              addr = {d, first_byte};
            end
          end
        end
        OP_DATA_WR: begin
          second_byte = 1'b0;
          if (addr[15:14] != 2'b11) begin
            vram[addr[13:0]] = d;
            vram_written[addr[13:0]] = 1'b1;
          end else begin
            ci = handheld ? addr[5:0] : {1'b0, addr[4:0]};
            cram[ci] = d;
            cram_written[ci] = 1'b1;
            pal_dirty = 1'b1;
          end
          addr = addr + 16'd1;
        end
        OP_DATA_RD: begin
          second_byte = 1'b0;
          r.rd_byte = 8'hff;
          if (!addr[15]) r.rd_byte = vram[addr[13:0]];
          else if (addr[15:14] == 2'b11) r.rd_byte = cram[addr[5:0]];
          addr = addr + 16'd1;
        end
        OP_LINE_TICK: begin
          line_tick(irq, fin);
          r.int_req = irq;
          r.frame_done = fin;
        end
        OP_CLR_FRAME: frame_f = 1'b0;
        OP_CLR_LINE:  line_f = 1'b0;
        OP_CLR_IRQ:   pend_f = 1'b0;
        OP_POLL_PAL: begin
          r.pal_changed = pal_dirty;
          pal_dirty = 1'b0;
        end
        OP_REG_RD: r.reg_value = mode_regs[n[3:0]];
        OP_COLOUR_RD: begin
          if (handheld) begin
            lo = cram[{n, 1'b0}];
            hi = cram[{n, 1'b1}];
            r.red   = {lo[3:1], 5'b0};
            r.green = {lo[7:5], 5'b0};
            r.blue  = {hi[3:1], 5'b0};
          end else begin
            c = cram[{1'b0, n}];
            r.red   = {c[1:0], 6'b0};
            r.green = {c[3:2], 6'b0};
            r.blue  = {c[5:4], 6'b0};
          end
        end
        default: ;
      endcase
      r.frame_irq = frame_f;
      r.line_irq = line_f;
      r.irq_pend = pend_f;
      r.line_num = vcount;
      owed_results.push_back(r);
    endfunction

    function void compare(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      end
    endfunction

    function void check_result(logic [55:0] beat);
      vdp_result_t got, want;
      got = vdp_result_t'(beat[54:0]);
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, beat);
        return;
      end
      want = owed_results.pop_front();
      compare("read_byte", want.rd_byte, got.rd_byte);
      compare("int_request", want.int_req, got.int_req);
      compare("frame_finished", want.frame_done, got.frame_done);
      compare("frame_irq_flag", want.frame_irq, got.frame_irq);
      compare("line_irq_flag", want.line_irq, got.line_irq);
      compare("irq_pending", want.irq_pend, got.irq_pend);
      compare("line_number", want.line_num, got.line_num);
      compare("palette_changed", want.pal_changed, got.pal_changed);
      compare("register_value", want.reg_value, got.reg_value);
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic        cfg_data;

  vdp_result_board sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          sec_items;
  int          sec_ticks;
  int          cycle_count = 0;

  vdp_port_and_line_interrupt_unit #(
    .LAST_LINE(FRAME_LAST_LINE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result beat monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // send one beat; reads of never-written memory are steered elsewhere
  task automatic send_beat(input logic [3:0] op_in, input logic [7:0] d,
                           input logic [4:0] idx);
    logic [3:0] op;
    logic [4:0] n;
    int         k;
    op = op_in;
    n = idx;
    if (!sb.read_ok(op, n)) begin
      if (op == OP_DATA_RD) begin
        op = OP_DATA_WR;
      end else begin
        k = 0;
        while (k < 32 && !sb.read_ok(op, idx + 5'(k))) k++;
        if (k < 32) n = idx + 5'(k);
        else op = OP_REG_RD;
      end
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, n, d};
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_accepted(op, d, n);
    sec_items++;
    if (op == OP_LINE_TICK) sec_ticks++;
  endtask

  // hold off until every owed result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input bit v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_config(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_address(input logic [15:0] a);
    send_beat(OP_CTRL_WR, a[7:0], 5'($urandom));
    send_beat(OP_CTRL_WR, a[15:8], 5'($urandom));
  endtask

  // address with a high byte biased toward a few regions so reads hit writes
  function automatic logic [15:0] pick_address();
    logic [7:0] hb;
    case ($urandom_range(0, 7))
      0: hb = 8'h00;
      1: hb = 8'h3f;
      2: hb = 8'h40;
      3: hb = 8'h7f;
      4: hb = 8'hc0;
      5: hb = 8'hff;
      6: hb = {2'b11, 6'($urandom)};
      default: hb = 8'($urandom);
    endcase
    // keep clear of the register write code
    if (hb[7:4] == REG_WR_CODE) hb[6] = 1'b1;
    return {hb, 8'($urandom)};
  endfunction

  // one random well-formed sequence, or a piece of noise
  task automatic random_sequence();
    logic [15:0] a;
    logic [3:0]  rn;
    logic [7:0]  v;
    int          cnt;
    int          kind;
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      repeat ($urandom_range(10, 60))
        send_beat(OP_LINE_TICK, 8'($urandom), 5'($urandom));
    end else if (kind < 48) begin
      // write a run, then read it back
      a = pick_address();
      cnt = $urandom_range(1, 6);
      set_address(a);
      repeat (cnt) send_beat(OP_DATA_WR, 8'($urandom), 5'($urandom));
      set_address(a);
      repeat (cnt) send_beat(OP_DATA_RD, 8'($urandom), 5'($urandom));
    end else if (kind < 60) begin
      set_address(pick_address());
      repeat ($urandom_range(1, 6))
        send_beat($urandom_range(0, 1) ? OP_DATA_WR : OP_DATA_RD, 8'($urandom),
                  5'($urandom));
    end else if (kind < 74) begin
      case ($urandom_range(0, 3))
        0: rn = REG_MODE0;
        1: rn = REG_MODE1;
        2: rn = REG_LINE_CNT;
        default: rn = 4'($urandom);
      endcase
      v = 8'($urandom);
      if (rn == REG_LINE_CNT && $urandom_range(0, 3) != 0) v = 8'($urandom_range(0, 7));
      send_beat(OP_CTRL_WR, v, 5'($urandom));
      send_beat(OP_CTRL_WR, {REG_WR_CODE, rn}, 5'($urandom));
    end else begin
      case ($urandom_range(0, 8))
        0: send_beat(OP_CLR_FRAME, 8'($urandom), 5'($urandom));
        1: send_beat(OP_CLR_LINE, 8'($urandom), 5'($urandom));
        2: send_beat(OP_CLR_IRQ, 8'($urandom), 5'($urandom));
        3: send_beat(OP_POLL_PAL, 8'($urandom), 5'($urandom));
        4: send_beat(OP_REG_RD, 8'($urandom), 5'($urandom));
        5, 6: send_beat(OP_COLOUR_RD, 8'($urandom), 5'($urandom));
        7: send_beat(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), 8'($urandom),
                     5'($urandom));
        default: send_beat(OP_CTRL_WR, 8'($urandom), 5'($urandom));
      endcase
    end
  endtask

  task automatic directed_pass();
    send_beat(OP_REG_RD, 8'h00, 5'd31);
    send_beat(OP_CTRL_WR, 8'h10, 5'd0);
    send_beat(OP_CTRL_WR, {REG_WR_CODE, REG_MODE0}, 5'd0);
    send_beat(OP_CTRL_WR, 8'h20, 5'd0);
    send_beat(OP_CTRL_WR, {REG_WR_CODE, REG_MODE1}, 5'd0);
    send_beat(OP_CTRL_WR, 8'h01, 5'd0);
    send_beat(OP_CTRL_WR, {REG_WR_CODE, REG_LINE_CNT}, 5'd0);
    // address 0xffff lands in colour RAM, the next write wraps to zero
    set_address(16'hffff);
    send_beat(OP_DATA_WR, 8'hff, 5'd31);
    send_beat(OP_DATA_WR, 8'h00, 5'd0);
    send_beat(OP_POLL_PAL, 8'h00, 5'd0);
    send_beat(OP_COLOUR_RD, 8'h00, 5'd31);
    // step from the top of video RAM into the unmapped region
    set_address(16'h7fff);
    send_beat(OP_DATA_WR, 8'h5a, 5'd0);
    send_beat(OP_DATA_RD, 8'h00, 5'd0);
    // lone first control byte, dropped by the next data access
    send_beat(OP_CTRL_WR, 8'hff, 5'd0);
    send_beat(OP_DATA_RD, 8'h00, 5'd0);
    repeat (3) send_beat(OP_LINE_TICK, 8'h00, 5'd0);
    send_beat(OP_CLR_LINE, 8'h00, 5'd0);
    send_beat(OP_CLR_IRQ, 8'h00, 5'd0);
    send_beat(OP_CLR_FRAME, 8'h00, 5'd0);
    send_beat(OP_UNUSED_HI, 8'hff, 5'd31);
    send_beat(OP_REG_RD, 8'h00, 5'd10);
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_pass();
    drain();

    // three sections: settings and stall patterns change between them
    for (int sec = 0; sec < 3; sec++) begin
      case (sec)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 46;
          cfg_write(CFG_HANDHELD, 1'b1);
          cfg_write(CFG_RENDER, 1'b0);
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 8;
          cfg_write(CFG_HANDHELD, 1'b0);
          cfg_write(CFG_RENDER, 1'b1);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          cfg_write(CFG_HANDHELD, 1'b1);
          cfg_write(CFG_RENDER, 1'b1);
        end
      endcase
      sec_items = 0;
      sec_ticks = 0;
      // the first two sections each cover at least one full frame
      while (sec_items < 250 || (sec < 2 && sec_ticks <= FRAME_LAST_LINE))
        random_sequence();
      drain();
    end

    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/vdppl_pkg.sv
hdl/vdppl_ram.sv
hdl/vdp_port_and_line_interrupt_unit.sv
tb/tb_vdp_port_and_line_interrupt_unit.sv
